/* design/kexp_pkg.sv */
// shared types and constants for the kronecker edge expander
package kexp_pkg;

    localparam int CFG_W   = 21;   // vertex count register width
    localparam int PART_W  = 5;    // partition count register width
    localparam int VPP_W   = 42;   // vertices per partition width
    localparam int QB      = 5;    // quotient bits below the saturation point
    localparam int QW      = QB + 1;
    localparam int ID_W    = 40;   // product id field width
    localparam int PID_W   = 4;    // partition id field width
    localparam int EDGE_W  = 48;   // partition counter field width
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [PID_W-1:0] PID_SAT = '1;

    // register index codes (byte address bits [3:2])
    localparam logic [1:0] REG_KRON  = 2'd0;
    localparam logic [1:0] REG_BASE  = 2'd1;
    localparam logic [1:0] REG_PARTS = 2'd2;
    localparam logic [1:0] REG_UNDIR = 2'd3;

    // two-entry queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    typedef struct packed {
        logic [CFG_W-1:0]  base_count;
        logic [PART_W-1:0] parts;       // zero already mapped to one
        logic              undirected;
        logic [VPP_W-1:0]  vpp;
        logic              busy;
    } t_cfg;

endpackage

/* design/kexp_cfg.sv */
// configuration registers and partition width computation
module kexp_cfg
    import kexp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_MUL  = 2'd1;
    localparam logic [1:0] C_DIV  = 2'd2;
    localparam logic [1:0] C_FIN  = 2'd3;

    logic [CFG_W-1:0]  r_kron;
    logic [CFG_W-1:0]  r_base;
    logic [PART_W-1:0] r_parts;
    logic              r_undir;
    logic [VPP_W-1:0]  r_vpp;
    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [VPP_W-1:0]  r_dq;
    logic [PART_W-1:0] r_drem;
    logic [5:0]        r_step;

    logic              w_wr;
    logic [1:0]        w_idx;
    logic [PART_W-1:0] w_parts;
    logic [VPP_W-1:0]  w_prod;
    logic [PART_W:0]   w_trial;
    logic              w_ge;
    logic [VPP_W-1:0]  w_ceil;

    assign pready  = 1'b1;
    assign w_wr    = psel & penable & pwrite;
    assign w_idx   = paddr[3:2];
    assign w_parts = (r_parts == '0) ? PART_W'(1) : r_parts;
    assign w_prod  = VPP_W'(r_kron) * VPP_W'(r_base);
    assign w_trial = {r_drem, r_dq[VPP_W-1]};
    assign w_ge    = w_trial >= {1'b0, w_parts};
    assign w_ceil  = r_dq + VPP_W'(r_drem != '0);

    always_comb begin
        unique case (w_idx)
            REG_KRON:  prdata = DATA_W'(r_kron);
            REG_BASE:  prdata = DATA_W'(r_base);
            REG_PARTS: prdata = DATA_W'(r_parts);
            REG_UNDIR: prdata = DATA_W'(r_undir);
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            C_IDLE: n_state = C_IDLE;
            C_MUL:  n_state = C_DIV;
            C_DIV:  if (r_step == '0) n_state = C_FIN;
            C_FIN:  n_state = C_IDLE;
        endcase
        if (w_wr) n_state = C_MUL;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kron  <= CFG_W'(1);
            r_base  <= CFG_W'(1);
            r_parts <= PART_W'(1);
            r_undir <= 1'b0;
            r_vpp   <= VPP_W'(1);
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
            if (w_wr) begin
                unique case (w_idx)
                    REG_KRON:  r_kron  <= pwdata[CFG_W-1:0];
                    REG_BASE:  r_base  <= pwdata[CFG_W-1:0];
                    REG_PARTS: r_parts <= pwdata[PART_W-1:0];
                    REG_UNDIR: r_undir <= pwdata[0];
                endcase
            end
            if (r_state == C_FIN && !w_wr)
                r_vpp <= (w_ceil == '0) ? VPP_W'(1) : w_ceil;
        end
    end

    // restoring divide of the vertex total, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (r_state == C_MUL) begin
            r_dq   <= w_prod;
            r_drem <= '0;
            r_step <= 6'(VPP_W - 1);
        end else if (r_state == C_DIV) begin
            r_dq   <= {r_dq[VPP_W-2:0], w_ge};
            r_drem <= w_ge ? PART_W'(w_trial - {1'b0, w_parts}) : w_trial[PART_W-1:0];
            r_step <= r_step - 6'd1;
        end
    end

    assign o_cfg.base_count = r_base;
    assign o_cfg.parts      = w_parts;
    assign o_cfg.undirected = r_undir;
    assign o_cfg.vpp        = r_vpp;
    assign o_cfg.busy       = (r_state != C_IDLE);

endmodule

/* design/kexp_front.sv */
// front end: takes edge pairs, filters backward pairs, forms product ids
module kexp_front
    import kexp_pkg::*;
#(
    parameter int VERTEX_BITS = 20,
    parameter int PROD_W      = VERTEX_BITS + CFG_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cfg                   i_cfg,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [VERTEX_BITS-1:0] i_kron_src,
    input  logic [VERTEX_BITS-1:0] i_kron_dst,
    input  logic [VERTEX_BITS-1:0] i_base_src,
    input  logic [VERTEX_BITS-1:0] i_base_dst,
    output logic                   o_push,
    input  logic                   i_full,
    output logic                   o_kept,
    output logic [PROD_W-1:0]      o_vs,
    output logic [PROD_W-1:0]      o_vd
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MS   = 2'd1;
    localparam logic [1:0] F_MD   = 2'd2;
    localparam logic [1:0] F_PUSH = 2'd3;

    logic [1:0]             r_state;
    logic [1:0]             n_state;
    logic [VERTEX_BITS-1:0] r_ks, r_kd, r_bs, r_bd;
    logic                   r_kept;
    logic [PROD_W-1:0]      r_prod;
    logic [PROD_W-1:0]      r_vs;
    logic                   w_accept;
    logic                   w_drop;

    assign o_in_stall = (r_state != F_IDLE) | i_cfg.busy;
    assign w_accept   = i_in_valid & ~o_in_stall;
    assign w_drop     = i_cfg.undirected &
                        ((i_kron_dst < i_kron_src) |
                         ((i_kron_dst == i_kron_src) & (i_base_dst < i_base_src)));

    assign o_push = (r_state == F_PUSH) & ~i_full;
    assign o_kept = r_kept;
    assign o_vs   = r_vs;
    assign o_vd   = r_prod + PROD_W'(r_bd);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: if (w_accept) n_state = w_drop ? F_PUSH : F_MS;
            F_MS:   n_state = F_MD;
            F_MD:   n_state = F_PUSH;
            F_PUSH: if (!i_full) n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= F_IDLE;
        else          r_state <= n_state;
    end

    // one multiplier shared by both endpoints
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ks   <= i_kron_src;
            r_kd   <= i_kron_dst;
            r_bs   <= i_base_src;
            r_bd   <= i_base_dst;
            r_kept <= ~w_drop;
        end
        if (r_state == F_MS)
            r_prod <= PROD_W'(r_ks) * PROD_W'(i_cfg.base_count);
        if (r_state == F_MD) begin
            r_vs   <= r_prod + PROD_W'(r_bs);
            r_prod <= PROD_W'(r_kd) * PROD_W'(i_cfg.base_count);
        end
    end

endmodule

/* design/kexp_fifo.sv */
// two-entry queue between front and back
module kexp_fifo
    import kexp_pkg::*;
#(
    parameter int W = 1
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_wdata,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_rdata,
    output logic         o_empty
);

    logic [W-1:0]       r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + Q_PTR_W'(1);
            if (i_pop)  r_rp <= r_rp + Q_PTR_W'(1);
            r_cnt <= r_cnt + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
    end

endmodule

/* design/kexp_back.sv */
// back end: partition lookup, counter update and result register
module kexp_back
    import kexp_pkg::*;
#(
    parameter int MAX_PARTITIONS = 16,
    parameter int COUNT_BITS     = 48,
    parameter int PROD_W         = 41
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_empty,
    output logic              o_pop,
    input  logic              i_kept,
    input  logic [PROD_W-1:0] i_vs,
    input  logic [PROD_W-1:0] i_vd,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_kept,
    output logic [ID_W-1:0]   o_out_src,
    output logic [ID_W-1:0]   o_out_dst,
    output logic [PID_W-1:0]  o_src_part,
    output logic [PID_W-1:0]  o_dst_part,
    output logic [EDGE_W-1:0] o_src_part_edges,
    output logic [EDGE_W-1:0] o_dst_part_edges,
    output logic              o_range_error
);

    localparam int IDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
    localparam int SH_W  = VPP_W + QB;
    localparam int DW    = (PROD_W > SH_W) ? PROD_W : SH_W;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_DIV  = 3'd1;
    localparam logic [2:0] B_CHK  = 3'd2;
    localparam logic [2:0] B_RDS  = 3'd3;
    localparam logic [2:0] B_WRS  = 3'd4;
    localparam logic [2:0] B_RDD  = 3'd5;
    localparam logic [2:0] B_WRD  = 3'd6;
    localparam logic [2:0] B_OUT  = 3'd7;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic                  r_kept;
    logic [PROD_W-1:0]     r_vs;
    logic [PROD_W-1:0]     r_vd;
    logic [PROD_W-1:0]     r_rem;
    logic [2:0]            r_k;
    logic [QW-1:0]         r_q;
    logic                  r_which;
    logic [QW-1:0]         r_qs;
    logic [QW-1:0]         r_qd;
    logic                  r_err;
    logic [COUNT_BITS-1:0] r_cnt_s;
    logic [COUNT_BITS-1:0] r_cnt_d;
    logic [COUNT_BITS-1:0] r_total;
    logic                  r_out_valid;

    logic [COUNT_BITS-1:0] r_mem [MAX_PARTITIONS];
    logic                  r_vld [MAX_PARTITIONS];
    logic [COUNT_BITS-1:0] r_rd_data;
    logic                  r_rd_vld;

    logic [DW-1:0]         w_shift;
    logic                  w_ge;
    logic [QW-1:0]         w_q;
    logic                  w_done;
    logic                  w_ok;
    logic [IDX_W-1:0]      w_idx_s;
    logic [IDX_W-1:0]      w_idx_d;
    logic [IDX_W-1:0]      w_raddr;
    logic [COUNT_BITS-1:0] w_inc;
    logic                  w_load;

    // shift-subtract divide, saturating at 2**QB
    assign w_shift = DW'(i_cfg.vpp) << r_k;
    assign w_ge    = DW'(r_rem) >= w_shift;
    assign w_q     = w_ge ? (r_q | (QW'(1) << r_k)) : r_q;
    assign w_done  = (w_ge && r_k == 3'(QB)) || (r_k == '0);

    assign w_ok    = (r_qs < QW'(i_cfg.parts)) && (r_qd < QW'(i_cfg.parts)) &&
                     (32'(r_qs) < MAX_PARTITIONS) && (32'(r_qd) < MAX_PARTITIONS);
    assign w_idx_s = IDX_W'(r_qs);
    assign w_idx_d = IDX_W'(r_qd);
    assign w_raddr = (r_state == B_RDS) ? w_idx_s : w_idx_d;
    assign w_inc   = (r_rd_vld ? r_rd_data : '0) + COUNT_BITS'(1);
    assign w_load  = (r_state == B_OUT) && (!r_out_valid || !i_out_stall);
    assign o_pop   = (r_state == B_IDLE) && !i_empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: if (!i_empty) n_state = i_kept ? B_DIV : B_OUT;
            B_DIV:  if (w_done && r_which) n_state = B_CHK;
            B_CHK:  n_state = w_ok ? B_RDS : B_OUT;
            B_RDS:  n_state = B_WRS;
            B_WRS:  n_state = B_RDD;
            B_RDD:  n_state = B_WRD;
            B_WRD:  n_state = B_OUT;
            B_OUT:  if (w_load) n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_CHK) r_total <= r_total + COUNT_BITS'(1);
            if (w_load)            r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                r_kept  <= i_kept;
                r_vs    <= i_vs;
                r_vd    <= i_vd;
                r_rem   <= i_vs;
                r_k     <= 3'(QB);
                r_q     <= '0;
                r_which <= 1'b0;
                r_err   <= 1'b0;
            end
            B_DIV: begin
                if (w_done) begin
                    if (r_which) r_qd <= w_q;
                    else         r_qs <= w_q;
                    r_rem   <= r_vd;
                    r_k     <= 3'(QB);
                    r_q     <= '0;
                    r_which <= 1'b1;
                end else begin
                    if (w_ge) r_rem <= PROD_W'(DW'(r_rem) - w_shift);
                    r_q <= w_q;
                    r_k <= r_k - 3'd1;
                end
            end
            B_CHK: r_err <= !w_ok;
            B_WRS: r_cnt_s <= w_inc;
            B_WRD: r_cnt_d <= w_inc;
            B_RDS, B_RDD, B_OUT: ;
        endcase
    end

    // partition counters, registered read, valid bit per entry
    always_ff @(posedge i_clk) begin
        if (r_state == B_WRS) r_mem[w_idx_s] <= w_inc;
        if (r_state == B_WRD) r_mem[w_idx_d] <= w_inc;
        r_rd_data <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PARTITIONS; i++) r_vld[i] <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            if (r_state == B_WRS) r_vld[w_idx_s] <= 1'b1;
            if (r_state == B_WRD) r_vld[w_idx_d] <= 1'b1;
            r_rd_vld <= r_vld[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            o_kept    <= r_kept;
            o_out_src <= r_kept ? ID_W'(r_vs) : '0;
            o_out_dst <= r_kept ? ID_W'(r_vd) : '0;
            o_src_part <= !r_kept ? '0 : (r_qs > QW'(PID_SAT)) ? PID_SAT : PID_W'(r_qs);
            o_dst_part <= !r_kept ? '0 : (r_qd > QW'(PID_SAT)) ? PID_SAT : PID_W'(r_qd);
            o_src_part_edges <= (!r_kept || r_err) ? '0 :
                                (r_qs == r_qd) ? EDGE_W'(r_cnt_d) : EDGE_W'(r_cnt_s);
            o_dst_part_edges <= (!r_kept || r_err) ? '0 : EDGE_W'(r_cnt_d);
            o_range_error    <= r_kept && r_err;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* design/kronecker_edge_expand_partition.sv */
// top level of the kronecker product edge expander with partition counters
// Each input transaction carries one seed-graph edge and one base-graph edge; the block
// returns exactly one result transaction for it: the product edge ids
// (kron*base_vertex_count+base, low 40 bits), the partition of each endpoint
// (id divided by ceil(total vertices / partition_count), shown saturated at 15),
// and the partition edge counters after the update. in undirected mode backward
// pairs come back with kept low and all other fields zero. an endpoint whose
// partition is not below partition_count and MAX_PARTITIONS raises range_error,
// leaves the counters alone and returns zero counts. the front forms the two
// product ids of a kept item in turn on its shared multiplier (a dropped item
// skips it) and takes no new input until the item is pushed; the back pops the
// queue, runs its shift-subtract partition divider on each endpoint in turn,
// checks the range, does the read-modify-write of the counter memory and loads
// the output register, and a dropped item goes from the pop straight to the load.
// a two-entry queue separates front and back and the output register lets the
// back start the next item while a result waits. every register write reruns
// the partition width computation (one multiply plus a 42-step divide), during
// which input is stalled. counters reset to zero with reset.
module kronecker_edge_expand_partition
    import kexp_pkg::*;
#(
    parameter int MAX_PARTITIONS = 16,
    parameter int VERTEX_BITS    = 20,
    parameter int COUNT_BITS     = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    // input channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [VERTEX_BITS-1:0] i_kron_src,
    input  logic [VERTEX_BITS-1:0] i_kron_dst,
    input  logic [VERTEX_BITS-1:0] i_base_src,
    input  logic [VERTEX_BITS-1:0] i_base_dst,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_kept,
    output logic [ID_W-1:0]        o_out_src,
    output logic [ID_W-1:0]        o_out_dst,
    output logic [PID_W-1:0]       o_src_part,
    output logic [PID_W-1:0]       o_dst_part,
    output logic [EDGE_W-1:0]      o_src_part_edges,
    output logic [EDGE_W-1:0]      o_dst_part_edges,
    output logic                   o_range_error
);

    // product id fits vertex bits plus the base count width
    localparam int PROD_W = VERTEX_BITS + CFG_W;
    localparam int JOB_W  = 1 + 2 * PROD_W;

    t_cfg              w_cfg;
    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_empty;
    logic              w_f_kept;
    logic [PROD_W-1:0] w_f_vs;
    logic [PROD_W-1:0] w_f_vd;
    logic [JOB_W-1:0]  w_q_in;
    logic [JOB_W-1:0]  w_q_out;

    // registers and the vertices-per-partition figure
    kexp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // accept, filter and form product ids
    kexp_front #(
        .VERTEX_BITS (VERTEX_BITS),
        .PROD_W      (PROD_W)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kron_src (i_kron_src),
        .i_kron_dst (i_kron_dst),
        .i_base_src (i_base_src),
        .i_base_dst (i_base_dst),
        .o_push     (w_push),
        .i_full     (w_full),
        .o_kept     (w_f_kept),
        .o_vs       (w_f_vs),
        .o_vd       (w_f_vd)
    );

    assign w_q_in = {w_f_kept, w_f_vs, w_f_vd};

    // decouples the front from the back
    kexp_fifo #(
        .W (JOB_W)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_q_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_rdata (w_q_out),
        .o_empty (w_empty)
    );

    // partition lookup, counter update, result register
    kexp_back #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .COUNT_BITS     (COUNT_BITS),
        .PROD_W         (PROD_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_empty          (w_empty),
        .o_pop            (w_pop),
        .i_kept           (w_q_out[JOB_W-1]),
        .i_vs             (w_q_out[2*PROD_W-1:PROD_W]),
        .i_vd             (w_q_out[PROD_W-1:0]),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kept           (o_kept),
        .o_out_src        (o_out_src),
        .o_out_dst        (o_out_dst),
        .o_src_part       (o_src_part),
        .o_dst_part       (o_dst_part),
        .o_src_part_edges (o_src_part_edges),
        .o_dst_part_edges (o_dst_part_edges),
        .o_range_error    (o_range_error)
    );

endmodule
